[hw/rtl/iidl_pkg.sv]
// package for the indexed insert/delete list
// holds the command and status codes, the transfer payload structs and the cell control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iidl_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int POS_W  = 7;
   localparam int LEN_W  = 7;
   localparam int STAT_W = 2;

   localparam logic [CMD_W-1:0] CMD_READ       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_HEAD   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS_TAIL   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INS_POS    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE_POS = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STAT_W-1:0]        status;
      logic [LEN_W-1:0]         length;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/iidl_cell.sv]
// one storage cell of the list chain
// shifts toward the tail on insert and toward the head on delete; depends on iidl_pkg
`timescale 1ns / 1ps
`default_nettype none

module iidl_cell
   import iidl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int INDEX    = 0
) (
   input  wire logic                        clock,
   input  wire cell_ctl_type                ctl,
   input  wire logic [$clog2(CAPACITY)-1:0] pos,
   input  wire logic [DATA_W-1:0]           ins_value,
   input  wire logic [DATA_W-1:0]           left_data,
   input  wire logic [DATA_W-1:0]           right_data,
   output logic      [DATA_W-1:0]           data,
   output logic      [DATA_W-1:0]           rd_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.insert) begin
         if (MY_INDEX > pos) begin
            data_in = left_data;
         end else if (MY_INDEX == pos) begin
            data_in = ins_value;
         end
      end else if (ctl.remove) begin
         if (MY_INDEX >= pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   // only the addressed cell drives the read bus
   assign rd_data = (MY_INDEX == pos) ? data_ff : '0;

endmodule

`default_nettype wire

[hw/rtl/indexed_insert_delete_list.sv]
// indexed insert/delete list: the response is registered, valid in the cycle after the
// request transfer; throughput one command per cycle while responses drain; every cell
// of the chain shifts in the same cycle, so inserts and deletes cost no more than reads
// a new request is taken while the response register is empty or being drained
// reset (synchronous) clears the entry count and the response valid; cell contents are
// not cleared since slots at or above the count are never read
`timescale 1ns / 1ps
`default_nettype none

module indexed_insert_delete_list
   import iidl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;

   logic              accept;
   logic              full;
   logic [PW-1:0]     pos_wide;
   logic [PW-1:0]     count_wide;
   logic [PW-1:0]     eff_pos;
   logic              do_insert;
   logic              do_remove;
   logic              do_read;
   logic [STAT_W-1:0] status;
   cell_ctl_type      ctl;
   logic [IW-1:0]     cell_pos;
   logic [DATA_W-1:0] rd_or;

   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_rd   [CAPACITY];

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign full       = (count_ff == CW'(CAPACITY));
   assign pos_wide   = PW'(req_data.position);
   assign count_wide = PW'(count_ff);

   always_comb begin
      status    = ST_DONE;
      do_insert = 1'b0;
      do_remove = 1'b0;
      do_read   = 1'b0;
      eff_pos   = pos_wide;
      case (req_data.command)
         CMD_READ: begin
            if (pos_wide < count_wide) begin
               do_read = 1'b1;
            end else begin
               status = ST_RANGE;
            end
         end
         CMD_INS_HEAD: begin
            eff_pos = '0;
            if (full) begin
               status = ST_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         CMD_INS_TAIL: begin
            eff_pos = count_wide;
            if (full) begin
               status = ST_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         CMD_INS_POS: begin
            // range is checked before fullness
            if (pos_wide > count_wide) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         CMD_DELETE_POS: begin
            if (pos_wide >= count_wide) begin
               status = ST_RANGE;
            end else begin
               do_remove = 1'b1;
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   // effective position is below CAPACITY whenever an operation goes ahead
   assign ctl.insert = accept && do_insert;
   assign ctl.remove = accept && do_remove;
   assign cell_pos   = eff_pos[IW-1:0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      iidl_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pos        (cell_pos),
         .ins_value  (req_data.value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   always_comb begin
      rd_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_data_in            = rsp_data_ff;
      rsp_valid_in           = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.read_value = do_read ? rd_or : '0;
         rsp_data_in.status     = status;
         rsp_data_in.length     = LEN_W'(count_in);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[tb/indexed_insert_delete_list_tb.sv]
// self-checking testbench for the indexed insert/delete list
// directed table then biased random commands, checked against a local list predictor
// depends on iidl_pkg and indexed_insert_delete_list
`timescale 1ns / 1ps

module indexed_insert_delete_list_tb;
   import iidl_pkg::*;

   localparam int LIST_CAP    = CAPACITY_DEFAULT;
   localparam int RAND_ITEMS  = 185;
   localparam int CYCLE_LIMIT = 200000;

   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

   localparam logic [DATA_W-1:0] EDGE_VALUES [4] =
      '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};

   typedef struct packed {
      req_type    req;
      logic       typed;
      rsp_type    want;
   } list_step_type;

   // typed rows carry the response by hand, the rest use the predictor
   localparam list_step_type DIRECTED [25] = '{
      {CMD_READ,       7'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
      {CMD_DELETE_POS, 7'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
      {CMD_DELETE_POS, 7'd5,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
      {CMD_INS_POS,    7'd1,   32'h1111_1111, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
      {CMD_INS_POS,    7'd0,   32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_DONE,  7'd1},
      {CMD_INS_HEAD,   7'd127, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_DONE,  7'd2},
      {CMD_INS_TAIL,   7'd0,   32'hffff_ffff, 1'b1, 32'h0000_0000, ST_DONE,  7'd3},
      {CMD_READ,       7'd0,   32'h0000_0000, 1'b1, 32'h8000_0000, ST_DONE,  7'd3},
      {CMD_READ,       7'd2,   32'hffff_ffff, 1'b1, 32'hffff_ffff, ST_DONE,  7'd3},
      {CMD_INS_POS,    7'd3,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE,  7'd4},
      {CMD_INS_POS,    7'd1,   32'h5555_5555, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
      {CMD_READ,       7'd1,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
      {CMD_INS_POS,    7'd6,   32'h2222_2222, 1'b1, 32'h0000_0000, ST_RANGE, 7'd5},
      {CMD_READ,       7'd5,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd5},
      {CMD_READ,       7'd127, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_RANGE, 7'd5},
      {CMD_DELETE_POS, 7'd127, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd5},
      {CMD_DELETE_POS, 7'd1,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
      {CMD_DELETE_POS, 7'd3,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
      {CMD_SPARE_A,    7'd64,  32'h1234_5678, 1'b1, 32'h0000_0000, ST_DONE,  7'd3},
      {CMD_SPARE_B,    7'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE,  7'd3},
      {CMD_SPARE_C,    7'd42,  32'haaaa_aaaa, 1'b1, 32'h0000_0000, ST_DONE,  7'd3},
      {CMD_READ,       7'd0,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
      {CMD_DELETE_POS, 7'd0,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
      {CMD_INS_HEAD,   7'd0,   32'h2aaa_aaaa, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
      {CMD_READ,       7'd64,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd3}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predictor state
   logic [DATA_W-1:0] list_cells [LIST_CAP];
   int unsigned       list_len = 0;
   bit                filling;

   rsp_type     pending_rsp [$];
   logic        row_typed;
   rsp_type     row_want;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   indexed_insert_delete_list #(
      .CAPACITY(LIST_CAP)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // applies one command to the local list and returns its response
   function automatic rsp_type list_apply(req_type r);
      rsp_type     o;
      int unsigned p;
      int unsigned at;
      int unsigned k;
      o = '0;
      p = r.position;
      case (r.command)
         CMD_READ: begin
            if (p < list_len) o.read_value = list_cells[p];
            else o.status = ST_RANGE;
         end
         CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
            if (r.command == CMD_INS_HEAD) at = 0;
            else if (r.command == CMD_INS_TAIL) at = list_len;
            else at = p;
            // range is checked before fullness
            if (at > list_len) begin
               o.status = ST_RANGE;
            end else if (list_len >= LIST_CAP) begin
               o.status = ST_FULL;
            end else begin
               for (k = list_len; k > at; k--) list_cells[k] = list_cells[k-1];
               list_cells[at] = r.value;
               list_len++;
            end
         end
         CMD_DELETE_POS: begin
            if (p >= list_len) begin
               o.status = ST_RANGE;
            end else begin
               for (k = p; k + 1 < list_len; k++) list_cells[k] = list_cells[k+1];
               list_len--;
            end
         end
         default: ;
      endcase
      o.length = list_len[LEN_W-1:0];
      return o;
   endfunction

   // random command biased toward filling the list up, then draining it
   function automatic req_type next_list_cmd();
      req_type     r;
      int unsigned roll;
      int unsigned len;
      bit          wild;
      len = list_len;
      if (filling && len >= LIST_CAP && $urandom_range(4) == 0) filling = 1'b0;
      else if (!filling && len == 0 && $urandom_range(2) == 0) filling = 1'b1;
      r.value = ($urandom_range(99) < 15) ? EDGE_VALUES[$urandom_range(3)] : $urandom;
      if ($urandom_range(99) < 8) begin
         r.command  = CMD_W'($urandom_range(7));
         r.position = POS_W'($urandom_range(127));
         return r;
      end
      roll = $urandom_range(99);
      if (filling) begin
         if (roll < 20) r.command = CMD_READ;
         else if (roll < 35) r.command = CMD_DELETE_POS;
         else if (roll < 50) r.command = CMD_INS_HEAD;
         else if (roll < 70) r.command = CMD_INS_TAIL;
         else r.command = CMD_INS_POS;
      end else begin
         if (roll < 25) r.command = CMD_READ;
         else if (roll < 75) r.command = CMD_DELETE_POS;
         else if (roll < 83) r.command = CMD_INS_HEAD;
         else if (roll < 91) r.command = CMD_INS_TAIL;
         else r.command = CMD_INS_POS;
      end
      wild = ($urandom_range(9) == 0);
      case (r.command)
         CMD_INS_POS: begin
            r.position = POS_W'(wild ? $urandom_range(127, len + 1) : $urandom_range(len));
         end
         CMD_READ, CMD_DELETE_POS: begin
            r.position = POS_W'((wild || len == 0) ? $urandom_range(127, len)
                                                   : $urandom_range(len - 1));
         end
         default: r.position = POS_W'($urandom_range(127));
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input req_type r, input logic typed, input rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      row_typed <= typed;
      row_want  <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("response with nothing pending", rsp_data.read_value, '0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_data.read_value, want.read_value);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.length !== want.length)
                  report_mismatch("length", 32'(rsp_data.length), 32'(want.length));
            end
         end
         if (req_valid && req_ready) begin
            got = list_apply(req_data);
            pending_rsp.push_back(row_typed ? row_want : got);
         end
      end
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("indexed_insert_delete_list: mismatch");
      $finish;
   end

   initial begin
      int unsigned n;
      int unsigned phase;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      row_typed      = 1'b0;
      row_want       = '0;
      filling        = 1'b1;
      send_idle_pct  = 35;
      recv_idle_pct  = 64;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (n = 0; n < $size(DIRECTED); n++)
         send_item(DIRECTED[n].req, DIRECTED[n].typed, DIRECTED[n].want);

      for (phase = 0; phase < 3; phase++) begin
         // hold off until the response side has caught up
         req_valid <= 1'b0;
         @(negedge clock);
         while (pending_rsp.size() != 0) @(negedge clock);
         case (phase)
            0: begin send_idle_pct = 35; recv_idle_pct = 64; end
            1: begin send_idle_pct = 64; recv_idle_pct = 35; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (n = 0; n < RAND_ITEMS; n++) send_item(next_list_cmd(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("indexed_insert_delete_list: match");
      end else begin
         $display("indexed_insert_delete_list: mismatch");
      end
      $finish;
   end

endmodule
